// File: design/dhbr_pkg.sv
// ----------------------------------------------------------------------------
// dhbr_pkg
// Shared opcodes, field layout and decode helpers for the decode stage.
// ----------------------------------------------------------------------------
package dhbr_pkg;

   localparam int DEF_PC_WIDTH   = 10;
   localparam int DEF_DATA_WIDTH = 32;

   localparam int OPC_WIDTH = 8;
   localparam int IDX_WIDTH = 4;
   localparam int IMM_WIDTH = 12;
   localparam int INSTR_WIDTH = 32;
   localparam int PEND_WIDTH = OPC_WIDTH + IDX_WIDTH;

   localparam logic [OPC_WIDTH-1:0] OP_SRL  = 8'd8;
   localparam logic [OPC_WIDTH-1:0] OP_BEQ  = 8'd9;
   localparam logic [OPC_WIDTH-1:0] OP_BNE  = 8'd10;
   localparam logic [OPC_WIDTH-1:0] OP_BLT  = 8'd11;
   localparam logic [OPC_WIDTH-1:0] OP_BGT  = 8'd12;
   localparam logic [OPC_WIDTH-1:0] OP_BLE  = 8'd13;
   localparam logic [OPC_WIDTH-1:0] OP_BGE  = 8'd14;
   localparam logic [OPC_WIDTH-1:0] OP_JAL  = 8'd15;
   localparam logic [OPC_WIDTH-1:0] OP_LW   = 8'd16;
   localparam logic [OPC_WIDTH-1:0] OP_SW   = 8'd17;
   localparam logic [OPC_WIDTH-1:0] OP_HALT = 8'd20;

   localparam logic [IDX_WIDTH-1:0] IDX_ZERO = 4'd0;
   localparam logic [IDX_WIDTH-1:0] IDX_IMM  = 4'd1;

   typedef struct packed {
      logic [OPC_WIDTH-1:0] opcode;
      logic [IDX_WIDTH-1:0] rd;
      logic [IDX_WIDTH-1:0] rs;
      logic [IDX_WIDTH-1:0] rt;
      logic [IMM_WIDTH-1:0] imm;
   } instr_fields_type;

   typedef struct packed {
      logic pc_redirect;
      logic link_write;
   } flow_ctl_type;

   function automatic instr_fields_type decode_instr(input logic [INSTR_WIDTH-1:0] word);
      instr_fields_type f;
      f.opcode = word[31:24];
      f.rd     = word[23:20];
      f.rs     = word[19:16];
      f.rt     = word[15:12];
      f.imm    = word[11:0];
      return f;
   endfunction

   function automatic logic op_writes_rd(input logic [OPC_WIDTH-1:0] op);
      return (op <= OP_SRL) || (op == OP_LW);
   endfunction

   function automatic logic op_is_branch(input logic [OPC_WIDTH-1:0] op);
      return (op >= OP_BEQ) && (op <= OP_BGE);
   endfunction

endpackage

// File: design/decode_hazard_and_branch_resolve_top.sv
// ----------------------------------------------------------------------------
// decode_hazard_and_branch_resolve_top
// Decode stage: hazard stall, operand resolve and branch/jal redirect.
// ----------------------------------------------------------------------------
// A req beat passes the input register and then the result register on its way to the rsp beat.
// Throughput: one beat per cycle while rsp_stall is low; set by the single registered decode pass.
// A full result register stalls the input only while rsp_stall is high.
// Reset (synchronous, active high) empties both register stages.
module decode_hazard_and_branch_resolve_top import dhbr_pkg::*; #(
   parameter int PC_WIDTH   = DEF_PC_WIDTH,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [INSTR_WIDTH-1:0]  req_instruction_word,
   input  logic [DATA_WIDTH-1:0]   req_rs_read_value,
   input  logic [DATA_WIDTH-1:0]   req_rt_read_value,
   input  logic [DATA_WIDTH-1:0]   req_rd_read_value,
   input  logic [PEND_WIDTH-1:0]   req_ex_pending,
   input  logic [PEND_WIDTH-1:0]   req_mem_pending,
   input  logic [PEND_WIDTH-1:0]   req_wb_pending,
   input  logic [PC_WIDTH-1:0]     req_fetch_pc,
   input  logic [OPC_WIDTH-1:0]    req_fetched_opcode,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_stall_res,
   output logic [DATA_WIDTH-1:0]   rsp_rs_value,
   output logic [DATA_WIDTH-1:0]   rsp_rt_value,
   output logic [DATA_WIDTH-1:0]   rsp_rd_value,
   output logic                    rsp_pc_redirect,
   output logic [PC_WIDTH-1:0]     rsp_next_pc,
   output logic                    rsp_link_write,
   output logic [PC_WIDTH:0]       rsp_link_value
);

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [INSTR_WIDTH-1:0]  iw_ff;
   logic [DATA_WIDTH-1:0]   rs_rd_ff, rt_rd_ff, rd_rd_ff;
   logic [PEND_WIDTH-1:0]   ex_ff, mem_ff, wb_ff;
   logic [PC_WIDTH-1:0]     pc_ff;
   logic [OPC_WIDTH-1:0]    fop_ff;

   // result register
   logic                    out_valid_ff, out_valid_in;
   logic                    stall_res_ff;
   logic [DATA_WIDTH-1:0]   rs_val_ff, rt_val_ff, rd_val_ff;
   logic                    redirect_ff, link_wr_ff;
   logic [PC_WIDTH-1:0]     npc_ff;
   logic [PC_WIDTH:0]       link_ff;

   logic                    out_adv, in_adv, req_take;
   instr_fields_type        fields;
   logic                    hazard;
   logic [DATA_WIDTH-1:0]   rs_val, rt_val, rd_val;
   flow_ctl_type            flow;
   logic [PC_WIDTH-1:0]     npc;
   logic [PC_WIDTH:0]       link;

   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign in_adv    = !in_valid_ff || out_adv;
   assign req_stall = !in_adv;
   assign req_take  = req_valid && in_adv;

   assign in_valid_in  = in_adv ? req_valid : in_valid_ff;
   assign out_valid_in = out_adv ? in_valid_ff : out_valid_ff;

   assign fields = decode_instr(iw_ff);

   dhbr_hazard u_hazard (
      .fields      (fields),
      .ex_pending  (ex_ff),
      .mem_pending (mem_ff),
      .wb_pending  (wb_ff),
      .hazard      (hazard)
   );

   dhbr_resolve #(
      .DATA_WIDTH (DATA_WIDTH),
      .PC_WIDTH   (PC_WIDTH)
   ) u_resolve (
      .fields         (fields),
      .rs_read_value  (rs_rd_ff),
      .rt_read_value  (rt_rd_ff),
      .rd_read_value  (rd_rd_ff),
      .fetch_pc       (pc_ff),
      .fetched_opcode (fop_ff),
      .rs_value       (rs_val),
      .rt_value       (rt_val),
      .rd_value       (rd_val),
      .flow           (flow),
      .next_pc        (npc),
      .link_value     (link)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         iw_ff    <= req_instruction_word;
         rs_rd_ff <= req_rs_read_value;
         rt_rd_ff <= req_rt_read_value;
         rd_rd_ff <= req_rd_read_value;
         ex_ff    <= req_ex_pending;
         mem_ff   <= req_mem_pending;
         wb_ff    <= req_wb_pending;
         pc_ff    <= req_fetch_pc;
         fop_ff   <= req_fetched_opcode;
      end
   end

   // a stalled beat carries only the stall flag, everything else zero
   always_ff @(posedge clock) begin
      if (out_adv && in_valid_ff) begin
         stall_res_ff <= hazard;
         rs_val_ff    <= hazard ? '0 : rs_val;
         rt_val_ff    <= hazard ? '0 : rt_val;
         rd_val_ff    <= hazard ? '0 : rd_val;
         redirect_ff  <= !hazard && flow.pc_redirect;
         npc_ff       <= hazard ? '0 : npc;
         link_wr_ff   <= !hazard && flow.link_write;
         link_ff      <= hazard ? '0 : link;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_stall_res   = stall_res_ff;
   assign rsp_rs_value    = rs_val_ff;
   assign rsp_rt_value    = rt_val_ff;
   assign rsp_rd_value    = rd_val_ff;
   assign rsp_pc_redirect = redirect_ff;
   assign rsp_next_pc     = npc_ff;
   assign rsp_link_write  = link_wr_ff;
   assign rsp_link_value  = link_ff;

endmodule

// File: design/dhbr_hazard.sv
// ----------------------------------------------------------------------------
// dhbr_hazard
// Read-after-write check against the execute, memory and writeback stages.
// ----------------------------------------------------------------------------
module dhbr_hazard import dhbr_pkg::*; (
   input  instr_fields_type        fields,
   input  logic [PEND_WIDTH-1:0]   ex_pending,
   input  logic [PEND_WIDTH-1:0]   mem_pending,
   input  logic [PEND_WIDTH-1:0]   wb_pending,
   output logic                    hazard
);

   logic [PEND_WIDTH-1:0] pend [3];
   logic [2:0]            hit;
   logic                  reads_src;
   logic                  reads_rd;

   assign pend[0] = ex_pending;
   assign pend[1] = mem_pending;
   assign pend[2] = wb_pending;

   assign reads_src = (fields.opcode != OP_JAL) && (fields.opcode != OP_HALT);
   assign reads_rd  = op_is_branch(fields.opcode) || (fields.opcode == OP_JAL) ||
                      (fields.opcode == OP_SW);

   function automatic logic uses_idx(input logic [IDX_WIDTH-1:0] idx,
                                     input logic [IDX_WIDTH-1:0] dst);
      return (idx == dst) && (idx != IDX_ZERO) && (idx != IDX_IMM);
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         hit[i] = op_writes_rd(pend[i][PEND_WIDTH-1:IDX_WIDTH]) &&
                  ((reads_src && (uses_idx(fields.rs, pend[i][IDX_WIDTH-1:0]) ||
                                  uses_idx(fields.rt, pend[i][IDX_WIDTH-1:0]))) ||
                   (reads_rd && uses_idx(fields.rd, pend[i][IDX_WIDTH-1:0])));
      end
   end

   assign hazard = |hit;

endmodule

// File: design/dhbr_resolve.sv
// ----------------------------------------------------------------------------
// dhbr_resolve
// Operand selection, signed branch compare, target and link generation.
// ----------------------------------------------------------------------------
module dhbr_resolve import dhbr_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH,
   parameter int PC_WIDTH   = DEF_PC_WIDTH
) (
   input  instr_fields_type        fields,
   input  logic [DATA_WIDTH-1:0]   rs_read_value,
   input  logic [DATA_WIDTH-1:0]   rt_read_value,
   input  logic [DATA_WIDTH-1:0]   rd_read_value,
   input  logic [PC_WIDTH-1:0]     fetch_pc,
   input  logic [OPC_WIDTH-1:0]    fetched_opcode,
   output logic [DATA_WIDTH-1:0]   rs_value,
   output logic [DATA_WIDTH-1:0]   rt_value,
   output logic [DATA_WIDTH-1:0]   rd_value,
   output flow_ctl_type            flow,
   output logic [PC_WIDTH-1:0]     next_pc,
   output logic [PC_WIDTH:0]       link_value
);

   localparam int WIDE = (DATA_WIDTH > PC_WIDTH) ? DATA_WIDTH : PC_WIDTH;

   logic [DATA_WIDTH-1:0] imm_ext;
   logic [WIDE-1:0]       rd_wide;
   logic                  taken;
   logic                  is_jal;
   logic                  halt_slot;

   function automatic logic [DATA_WIDTH-1:0] pick(input logic [IDX_WIDTH-1:0] idx,
                                                  input logic [DATA_WIDTH-1:0] imm,
                                                  input logic [DATA_WIDTH-1:0] rdata);
      logic [DATA_WIDTH-1:0] v;
      if (idx == IDX_ZERO)
         v = '0;
      else if (idx == IDX_IMM)
         v = imm;
      else
         v = rdata;
      return v;
   endfunction

   assign imm_ext  = DATA_WIDTH'($signed(fields.imm));
   assign rs_value = pick(fields.rs, imm_ext, rs_read_value);
   assign rt_value = pick(fields.rt, imm_ext, rt_read_value);
   assign rd_value = pick(fields.rd, imm_ext, rd_read_value);
   assign rd_wide  = WIDE'(rd_value);

   always_comb begin
      unique case (fields.opcode)
         OP_BEQ:  taken = (rs_value == rt_value);
         OP_BNE:  taken = (rs_value != rt_value);
         OP_BLT:  taken = ($signed(rs_value) <  $signed(rt_value));
         OP_BGT:  taken = ($signed(rs_value) >  $signed(rt_value));
         OP_BLE:  taken = ($signed(rs_value) <= $signed(rt_value));
         OP_BGE:  taken = ($signed(rs_value) >= $signed(rt_value));
         OP_JAL:  taken = 1'b1;
         default: taken = 1'b0;
      endcase
   end

   assign is_jal    = (fields.opcode == OP_JAL);
   // halt in the delay slot freezes fetch whether or not the branch is taken
   assign halt_slot = (op_is_branch(fields.opcode) || is_jal) && (fetched_opcode == OP_HALT);

   assign flow.pc_redirect = taken || halt_slot;
   assign flow.link_write  = is_jal;

   always_comb begin
      priority if (halt_slot)
         next_pc = fetch_pc;
      else if (taken)
         next_pc = rd_wide[PC_WIDTH-1:0];
      else
         next_pc = '0;
   end

   assign link_value = is_jal ? ({1'b0, fetch_pc} + (PC_WIDTH+1)'(1)) : '0;

endmodule
